@@ rtl/core/dlpg_pkg.sv @@
// Shared constants for the dashed line pixel generator.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package dlpg_pkg;

    // Default widths of the coordinate and pixel index fields.
    localparam int COORD_BITS_DEF = 13;
    localparam int INDEX_BITS_DEF = 12;

    // Dash configuration registers.
    localparam int DASH_BITS      = 8;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DASH_BITS-1:0] DASH_ON_RESET  = 8'd15;
    localparam logic [DASH_BITS-1:0] DASH_GAP_RESET = 8'd10;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_DASH_ON  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DASH_GAP = 2'd1;

endpackage

`default_nettype wire

@@ rtl/core/dlpg_intf.sv @@
// Valid/ready channel interfaces of the dashed line pixel generator.
// Depends on dlpg_pkg for default widths.
`default_nettype none

interface dlpg_line_if #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dlpg_pkg::INDEX_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic        [INDEX_BITS-1:0] pixel_index;

    modport source (
        output valid, start_x, start_y, end_x, end_y, pixel_index,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, pixel_index,
        output ready
    );
endinterface

interface dlpg_pixel_if #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         in_line;

    modport source (
        output valid, pixel_x, pixel_y, in_line,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, in_line,
        output ready
    );
endinterface

interface dlpg_cfg_if;
    import dlpg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DASH_BITS-1:0]      wdata;

    modport source (
        output valid, index, wdata,
        input  ready
    );
    modport sink (
        input  valid, index, wdata,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/dashed_line_pixel_generator_top.sv @@
// Top level of the dashed line pixel generator: configuration registers,
// pipeline stitching and output register. Depends on dlpg_pkg, dlpg_intf,
// dlpg_front, dlpg_pipe_div and dlpg_place.
//
//   Channel    Direction  Carries
//   line_req   in         start_x, start_y, end_x, end_y, pixel_index
//   pixel      out        pixel_x, pixel_y, in_line
//   cfg        in         index, wdata (dash_on, dash_gap)
//
// One transfer is accepted every cycle while the pipeline is not stalled.
// Items pass through the front end, the bit-per-stage dash position
// divider (INDEX_BITS stages), the placement stages, the bit-per-stage
// minor coordinate divider (COORD_BITS + 1 stages) and the output register.
// Reset clears all valid bits and loads dash_on = 15, dash_gap = 10.
// The pipeline moves whenever its last stage is empty or the output
// register can take that item; otherwise every stage holds its contents.
// cfg is always ready; writes take effect at once.
`default_nettype none

module dashed_line_pixel_generator_top #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dlpg_pkg::INDEX_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    dlpg_line_if.sink  line_req,
    dlpg_pixel_if.source pixel,
    dlpg_cfg_if.sink   cfg
);
    import dlpg_pkg::*;

    localparam int W      = COORD_BITS;
    localparam int PAY1_W = 4 * W + 4;
    localparam int PAY2_W = W + 3;

    logic [DASH_BITS-1:0] dash_on_reg;
    logic [DASH_BITS-1:0] dash_gap_reg;

    logic advance;
    logic out_load;

    // Front end outputs.
    logic                  f_valid;
    logic signed [W-1:0]   f_m1, f_n1;
    logic [W-1:0]          f_dm;
    logic signed [W:0]     f_dn;
    logic                  f_neg, f_is_x, f_ok;
    logic [INDEX_BITS-1:0] f_k;

    // Dash divider.
    logic [PAY1_W-1:0]     d1_pay_in, d1_pay_out;
    logic                  d1_valid;
    logic [INDEX_BITS-1:0] d1_quo;
    logic [DASH_BITS-1:0]  d1_rem;

    // Placement stage outputs.
    logic                  p_valid;
    logic [2*W:0]          p_mag;
    logic                  p_neg;
    logic [W-1:0]          p_den;
    logic [W-1:0]          p_major;
    logic                  p_is_x, p_hit;

    // Minor coordinate divider.
    logic [PAY2_W-1:0]     d2_pay_in, d2_pay_out;
    logic                  d2_valid;
    logic [W:0]            d2_quo;
    logic [W:0]            minor_signed;
    logic [W-1:0]          l_major;
    logic                  l_neg, l_is_x, l_hit;

    logic                  out_valid_reg;
    logic [W-1:0]          px_reg, px_next;
    logic [W-1:0]          py_reg, py_next;
    logic                  in_line_reg;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_on_reg  <= DASH_ON_RESET;
            dash_gap_reg <= DASH_GAP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DASH_ON:  dash_on_reg  <= cfg.wdata;
                REG_DASH_GAP: dash_gap_reg <= cfg.wdata;
                default:      ;
            endcase
        end
    end

    // Flow control.
    assign out_load       = !out_valid_reg || pixel.ready;
    assign advance        = !d2_valid || out_load;
    assign line_req.ready = advance;

    dlpg_front #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (line_req.valid),
        .x1         (line_req.start_x),
        .y1         (line_req.start_y),
        .x2         (line_req.end_x),
        .y2         (line_req.end_y),
        .k          (line_req.pixel_index),
        .out_valid  (f_valid),
        .m1         (f_m1),
        .n1         (f_n1),
        .dm         (f_dm),
        .dn         (f_dn),
        .major_neg  (f_neg),
        .major_is_x (f_is_x),
        .geom_ok    (f_ok),
        .k_out      (f_k)
    );

    assign d1_pay_in = {f_is_x, f_neg, f_ok, f_m1, f_n1, f_dm, f_dn};

    dlpg_pipe_div #(
        .NUM_W (INDEX_BITS),
        .DEN_W (DASH_BITS),
        .QUO_W (INDEX_BITS),
        .PAY_W (PAY1_W)
    ) u_dash_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (f_valid),
        .num       (f_k),
        .den       (dash_on_reg),
        .pay       (d1_pay_in),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .rem       (d1_rem),
        .pay_out   (d1_pay_out)
    );

    dlpg_place #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_place (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (d1_valid),
        .dash_quo   (d1_quo),
        .dash_rem   (d1_rem),
        .dash_on    (dash_on_reg),
        .dash_gap   (dash_gap_reg),
        .m1         (d1_pay_out[4*W:3*W+1]),
        .n1         (d1_pay_out[3*W:2*W+1]),
        .dm         (d1_pay_out[2*W:W+1]),
        .dn         (d1_pay_out[W:0]),
        .major_neg  (d1_pay_out[4*W+2]),
        .major_is_x (d1_pay_out[4*W+3]),
        .geom_ok    (d1_pay_out[4*W+1]),
        .out_valid  (p_valid),
        .num_mag    (p_mag),
        .num_neg    (p_neg),
        .den        (p_den),
        .major_out  (p_major),
        .is_x_out   (p_is_x),
        .hit        (p_hit)
    );

    assign d2_pay_in = {p_major, p_neg, p_is_x, p_hit};

    dlpg_pipe_div #(
        .NUM_W (2 * W + 1),
        .DEN_W (W),
        .QUO_W (W + 1),
        .PAY_W (PAY2_W)
    ) u_minor_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (p_valid),
        .num       (p_mag),
        .den       (p_den),
        .pay       (d2_pay_in),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .rem       (),
        .pay_out   (d2_pay_out)
    );

    // Truncation toward zero: divide the magnitude, then restore the sign.
    always_comb
    begin
        {l_major, l_neg, l_is_x, l_hit} = d2_pay_out;
        minor_signed = l_neg ? -d2_quo : d2_quo;
        if (!l_hit)
        begin
            px_next = '0;
            py_next = '0;
        end
        else if (l_is_x)
        begin
            px_next = l_major;
            py_next = minor_signed[W-1:0];
        end
        else
        begin
            px_next = minor_signed[W-1:0];
            py_next = l_major;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && d2_valid)
        begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            in_line_reg <= l_hit;
        end
    end

    assign pixel.valid   = out_valid_reg;
    assign pixel.pixel_x = px_reg;
    assign pixel.pixel_y = py_reg;
    assign pixel.in_line = in_line_reg;

    // A finished item that cannot move into the output register freezes
    // the whole pipeline, so nothing new may enter.
    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        d2_valid && out_valid_reg && !pixel.ready |-> !line_req.ready
    ) else $error("pipeline advanced over a stalled result");

    // A pixel outside the line comes out as zeros.
    a_miss_is_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.in_line |-> pixel.pixel_x == '0 && pixel.pixel_y == '0
    ) else $error("pixel outside the line carries nonzero coordinates");

    // A zero dash length draws nothing.
    a_zero_dash_draws_nothing: assert property (
        @(posedge clk) disable iff (!rst_n)
        pixel.valid && dash_on_reg == '0 |-> !pixel.in_line
    ) else $error("pixel drawn with zero dash length");

    // The output register only fills from a valid last stage.
    a_output_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !d2_valid |=> !pixel.valid
    ) else $error("result appeared without a finished item");

endmodule

`default_nettype wire

@@ rtl/core/dlpg_front.sv @@
// Front end: endpoint deltas, then major axis selection, over two stages.
// Depends on dlpg_pkg for default widths.
`default_nettype none

module dlpg_front #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dlpg_pkg::INDEX_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] x1,
    input  wire logic signed [COORD_BITS-1:0] y1,
    input  wire logic signed [COORD_BITS-1:0] x2,
    input  wire logic signed [COORD_BITS-1:0] y2,
    input  wire logic        [INDEX_BITS-1:0] k,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      m1,
    output logic signed [COORD_BITS-1:0]      n1,
    output logic        [COORD_BITS-1:0]      dm,
    output logic signed [COORD_BITS:0]        dn,
    output logic                              major_neg,
    output logic                              major_is_x,
    output logic                              geom_ok,
    output logic        [INDEX_BITS-1:0]      k_out
);
    import dlpg_pkg::*;

    localparam int W = COORD_BITS;

    // Stage 1: deltas.
    logic                 s1_valid_reg;
    logic signed [W:0]    dx_reg, dx_next;
    logic signed [W:0]    dy_reg, dy_next;
    logic signed [W-1:0]  x1_reg, y1_reg;
    logic [INDEX_BITS-1:0] k1_reg;

    // Stage 2: major axis selection.
    logic                 s2_valid_reg;
    logic signed [W-1:0]  m1_reg, m1_next;
    logic signed [W-1:0]  n1_reg, n1_next;
    logic [W-1:0]         dm_reg, dm_next;
    logic signed [W:0]    dn_reg, dn_next;
    logic                 neg_reg, neg_next;
    logic                 is_x_reg, is_x_next;
    logic                 ok_reg, ok_next;
    logic [INDEX_BITS-1:0] k2_reg;

    logic [W:0] adx;
    logic [W:0] ady;

    always_comb
    begin
        dx_next = {x2[W-1], x2} - {x1[W-1], x1};
        dy_next = {y2[W-1], y2} - {y1[W-1], y1};
    end

    always_comb
    begin
        adx = dx_reg[W] ? -dx_reg : dx_reg;
        ady = dy_reg[W] ? -dy_reg : dy_reg;
        is_x_next = adx > ady;
        if (is_x_next)
        begin
            // Only a line running toward larger x is drawn on the x axis.
            m1_next  = x1_reg;
            n1_next  = y1_reg;
            dm_next  = adx[W-1:0];
            dn_next  = dy_reg;
            neg_next = 1'b0;
            ok_next  = !dx_reg[W];
        end
        else
        begin
            m1_next  = y1_reg;
            n1_next  = x1_reg;
            dm_next  = ady[W-1:0];
            dn_next  = dx_reg;
            neg_next = dy_reg[W];
            ok_next  = dy_reg != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            x1_reg   <= x1;
            y1_reg   <= y1;
            k1_reg   <= k;
            m1_reg   <= m1_next;
            n1_reg   <= n1_next;
            dm_reg   <= dm_next;
            dn_reg   <= dn_next;
            neg_reg  <= neg_next;
            is_x_reg <= is_x_next;
            ok_reg   <= ok_next;
            k2_reg   <= k1_reg;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign m1         = m1_reg;
    assign n1         = n1_reg;
    assign dm         = dm_reg;
    assign dn         = dn_reg;
    assign major_neg  = neg_reg;
    assign major_is_x = is_x_reg;
    assign geom_ok    = ok_reg;
    assign k_out      = k2_reg;

endmodule

`default_nettype wire

@@ rtl/core/dlpg_pipe_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
// Carries a payload beside the operands. Depends on dlpg_pkg.
`default_nettype none

module dlpg_pipe_div #(
    parameter int NUM_W = dlpg_pkg::INDEX_BITS_DEF,
    parameter int DEN_W = dlpg_pkg::DASH_BITS,
    parameter int QUO_W = dlpg_pkg::INDEX_BITS_DEF,
    parameter int PAY_W = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [PAY_W-1:0] pay,
    output logic                  out_valid,
    output logic [QUO_W-1:0]      quo,
    output logic [DEN_W-1:0]      rem,
    output logic [PAY_W-1:0]      pay_out
);
    import dlpg_pkg::*;

    // The quotient must fit QUO_W bits, so num >> QUO_W is below den.
    // The low word starts as the remaining numerator bits and fills with
    // quotient bits from the bottom.
    logic [QUO_W-1:0] valid_reg;
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] low_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [PAY_W-1:0] pay_reg [QUO_W];

    logic             valid_in [QUO_W];
    logic [DEN_W-1:0] rem_in   [QUO_W];
    logic [QUO_W-1:0] low_in   [QUO_W];
    logic [DEN_W-1:0] den_in   [QUO_W];
    logic [PAY_W-1:0] pay_in   [QUO_W];

    always_comb
    begin
        valid_in[0] = in_valid;
        rem_in[0]   = DEN_W'(num >> QUO_W);
        low_in[0]   = num[QUO_W-1:0];
        den_in[0]   = den;
        pay_in[0]   = pay;
        for (int i = 1; i < QUO_W; i++)
        begin
            valid_in[i] = valid_reg[i-1];
            rem_in[i]   = rem_reg[i-1];
            low_in[i]   = low_reg[i-1];
            den_in[i]   = den_reg[i-1];
            pay_in[i]   = pay_reg[i-1];
        end
    end

    for (genvar g = 0; g < QUO_W; g++)
    begin : g_stage
        logic [DEN_W:0]   trial;
        logic             take;
        logic [DEN_W:0]   diff;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] low_next;

        always_comb
        begin
            trial    = {rem_in[g], low_in[g][QUO_W-1]};
            diff     = trial - {1'b0, den_in[g]};
            take     = trial >= {1'b0, den_in[g]};
            rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next = {low_in[g][QUO_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[g] <= valid_in[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[g] <= rem_next;
                low_reg[g] <= low_next;
                den_reg[g] <= den_in[g];
                pay_reg[g] <= pay_in[g];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = low_reg[QUO_W-1];
    assign rem       = rem_reg[QUO_W-1];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

`default_nettype wire

@@ rtl/core/dlpg_place.sv @@
// Places the pixel on the major axis and forms the minor axis numerator,
// over four stages. Depends on dlpg_pkg for widths.
`default_nettype none

module dlpg_place #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = dlpg_pkg::INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic                              in_valid,
    input  wire logic [INDEX_BITS-1:0]             dash_quo,
    input  wire logic [dlpg_pkg::DASH_BITS-1:0]    dash_rem,
    input  wire logic [dlpg_pkg::DASH_BITS-1:0]    dash_on,
    input  wire logic [dlpg_pkg::DASH_BITS-1:0]    dash_gap,
    input  wire logic signed [COORD_BITS-1:0]      m1,
    input  wire logic signed [COORD_BITS-1:0]      n1,
    input  wire logic        [COORD_BITS-1:0]      dm,
    input  wire logic signed [COORD_BITS:0]        dn,
    input  wire logic                              major_neg,
    input  wire logic                              major_is_x,
    input  wire logic                              geom_ok,
    output logic                                   out_valid,
    output logic [2*COORD_BITS:0]                  num_mag,
    output logic                                   num_neg,
    output logic [COORD_BITS-1:0]                  den,
    output logic [COORD_BITS-1:0]                  major_out,
    output logic                                   is_x_out,
    output logic                                   hit
);
    import dlpg_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int PROD_W = INDEX_BITS + DASH_BITS + 1;
    localparam int OFF_W  = INDEX_BITS + DASH_BITS + 2;

    // Stage 1: whole dash periods before the requested pixel.
    logic                 p1_valid_reg;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [DASH_BITS:0]   period;
    logic [DASH_BITS-1:0] rem1_reg;
    logic                 ok1_reg, ok1_next;
    logic signed [W-1:0]  m1_1_reg, n1_1_reg;
    logic [W-1:0]         dm1_reg;
    logic signed [W:0]    dn1_reg;
    logic                 neg1_reg, isx1_reg;

    // Stage 2: major offset and range check.
    logic                 p2_valid_reg;
    logic [OFF_W-1:0]     off_full;
    logic [W-1:0]         off_reg;
    logic                 hit2_reg, hit2_next;
    logic signed [W-1:0]  m1_2_reg, n1_2_reg;
    logic [W-1:0]         dm2_reg;
    logic signed [W:0]    dn2_reg;
    logic                 neg2_reg, isx2_reg;

    // Stage 3: products and major coordinate.
    logic                  p3_valid_reg;
    logic signed [2*W:0]   pa_reg, pa_next;
    logic signed [2*W+1:0] pb_reg, pb_next;
    logic [W:0]            major_sum;
    logic [W-1:0]          major3_reg;
    logic [W-1:0]          dm3_reg;
    logic                  hit3_reg, isx3_reg;

    // Stage 4: numerator sign and magnitude.
    logic                  p4_valid_reg;
    logic signed [2*W+1:0] num_sum;
    logic [2*W+1:0]        num_abs;
    logic [2*W:0]          mag_reg;
    logic                  sign_reg;
    logic [W-1:0]          major4_reg, dm4_reg;
    logic                  hit4_reg, isx4_reg;

    always_comb
    begin
        period    = {1'b0, dash_on} + {1'b0, dash_gap};
        prod_next = dash_quo * period;
        ok1_next  = geom_ok && (dash_on != '0);
    end

    // Pixel k sits at offset (k / on) * (on + gap) + (k % on) + 1.
    always_comb
    begin
        off_full  = OFF_W'(prod_reg) + OFF_W'(rem1_reg) + OFF_W'(1);
        hit2_next = ok1_reg && (off_full <= OFF_W'(dm1_reg));
    end

    always_comb
    begin
        pa_next   = n1_2_reg * $signed({1'b0, dm2_reg});
        pb_next   = $signed({1'b0, off_reg}) * dn2_reg;
        major_sum = neg2_reg ? {m1_2_reg[W-1], m1_2_reg} - {1'b0, off_reg}
                             : {m1_2_reg[W-1], m1_2_reg} + {1'b0, off_reg};
    end

    always_comb
    begin
        num_sum = $signed({pa_reg[2*W], pa_reg}) + pb_reg;
        num_abs = num_sum[2*W+1] ? -num_sum : num_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            rem1_reg   <= dash_rem;
            ok1_reg    <= ok1_next;
            m1_1_reg   <= m1;
            n1_1_reg   <= n1;
            dm1_reg    <= dm;
            dn1_reg    <= dn;
            neg1_reg   <= major_neg;
            isx1_reg   <= major_is_x;

            off_reg    <= off_full[W-1:0];
            hit2_reg   <= hit2_next;
            m1_2_reg   <= m1_1_reg;
            n1_2_reg   <= n1_1_reg;
            dm2_reg    <= dm1_reg;
            dn2_reg    <= dn1_reg;
            neg2_reg   <= neg1_reg;
            isx2_reg   <= isx1_reg;

            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            major3_reg <= major_sum[W-1:0];
            dm3_reg    <= dm2_reg;
            hit3_reg   <= hit2_reg;
            isx3_reg   <= isx2_reg;

            mag_reg    <= num_abs[2*W:0];
            sign_reg   <= num_sum[2*W+1];
            major4_reg <= major3_reg;
            dm4_reg    <= dm3_reg;
            hit4_reg   <= hit3_reg;
            isx4_reg   <= isx3_reg;
        end
    end

    assign out_valid = p4_valid_reg;
    assign num_mag   = mag_reg;
    assign num_neg   = sign_reg;
    assign den       = dm4_reg;
    assign major_out = major4_reg;
    assign is_x_out  = isx4_reg;
    assign hit       = hit4_reg;

endmodule

`default_nettype wire
